// ----- sv/fqd_pkg.sv -----
`timescale 1ns / 1ps
// Package for the FIFO queue with dump: opcodes, answer codes and the
// command and status structs passed between the controller and the datapath.
// Depends on nothing.
package fqd_pkg;

	// Opcode of an input word.
	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_DUMP = 2'd2;

	// Status code of a result word.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_ENTRY = 2'd3;

	localparam int unsigned DATA_W = 32;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       push_en;    // write the value at the tail
		logic       pop_en;     // advance the head
		logic       dump_load;  // load the walk pointer and the remaining count
		logic       dump_step;  // read one entry and advance the walk
		logic       res_valid;  // issue a result word
		logic [1:0] res_status;
		logic       res_last;
		logic       res_entry;  // the result carries the entry read from the ring
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic empty;
		logic rem_last;  // one entry left to walk in the current dump
	} dp_stat_t;

endpackage

// ----- sv/fqd_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the FIFO queue with dump: decodes the opcode of an accepted
// word and sequences the dump walk. Depends on fqd_pkg.
module fqd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        opcode,
	input  fqd_pkg::dp_stat_t stat,
	output fqd_pkg::dp_cmd_t  cmd,
	output logic              busy
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DUMP = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q == ST_DUMP);

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (opcode)
						fqd_pkg::OP_PUSH: begin
							cmd.res_valid  = 1'b1;
							cmd.res_last   = 1'b1;
							cmd.res_status = stat.full ? fqd_pkg::ST_FULL : fqd_pkg::ST_OK;
							cmd.push_en    = !stat.full;
						end
						fqd_pkg::OP_POP: begin
							cmd.res_valid  = 1'b1;
							cmd.res_last   = 1'b1;
							cmd.res_status = stat.empty ? fqd_pkg::ST_EMPTY : fqd_pkg::ST_OK;
							cmd.pop_en     = !stat.empty;
						end
						fqd_pkg::OP_DUMP: begin
							// An empty queue dumps nothing.
							if (!stat.empty) begin
								cmd.dump_load = 1'b1;
								state_d       = ST_DUMP;
							end
						end
						default: begin
							// The unused opcode is ignored.
						end
					endcase
				end
			end
			ST_DUMP: begin
				cmd.dump_step  = 1'b1;
				cmd.res_valid  = 1'b1;
				cmd.res_status = fqd_pkg::ST_ENTRY;
				cmd.res_last   = stat.rem_last;
				cmd.res_entry  = 1'b1;
				if (stat.rem_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- sv/fqd_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the FIFO queue with dump: the ring memory, head, tail, count,
// the dump walk pointer and the result register stage. Depends on fqd_pkg.
module fqd_dp #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic signed [fqd_pkg::DATA_W-1:0] value,
	input  fqd_pkg::dp_cmd_t                 cmd,
	output fqd_pkg::dp_stat_t                stat,
	output logic                             strobe,
	output logic signed [fqd_pkg::DATA_W-1:0] data,
	output logic [1:0]                       status,
	output logic                             last
);

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [fqd_pkg::DATA_W-1:0] ring_q [DEPTH];
	logic [fqd_pkg::DATA_W-1:0] rd_data_s1;
	logic [IDX_W-1:0]           head_q;
	logic [IDX_W-1:0]           tail_q;
	logic [IDX_W-1:0]           walk_q;
	logic [CNT_W-1:0]           count_q;
	logic [CNT_W-1:0]           rem_q;
	logic                       res_valid_s1;
	logic [1:0]                 res_status_s1;
	logic                       res_last_s1;
	logic                       res_entry_s1;

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
		next_idx = (idx == IDX_MAX) ? '0 : idx + 1'b1;
	endfunction

	// Status towards the controller.
	assign stat.full     = (count_q == CNT_FULL);
	assign stat.empty    = (count_q == '0);
	assign stat.rem_last = (rem_q == CNT_W'(1));

	// Ring memory: one write port for pushes, one registered read port for the dump walk.
	always_ff @(posedge clk) begin
		if (cmd.push_en) begin
			ring_q[tail_q] <= value;
		end
		if (cmd.dump_step) begin
			rd_data_s1 <= ring_q[walk_q];
		end
	end

	// Head, tail, count and dump walk pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			walk_q  <= '0;
			rem_q   <= '0;
		end else begin
			if (cmd.push_en) begin
				tail_q  <= next_idx(tail_q);
				count_q <= count_q + 1'b1;
			end
			if (cmd.pop_en) begin
				head_q  <= next_idx(head_q);
				count_q <= count_q - 1'b1;
			end
			if (cmd.dump_load) begin
				walk_q <= head_q;
				rem_q  <= count_q;
			end else if (cmd.dump_step) begin
				walk_q <= next_idx(walk_q);
				rem_q  <= rem_q - 1'b1;
			end
		end
	end

	// Result stage, aligned with the registered memory read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
		end else begin
			res_valid_s1 <= cmd.res_valid;
		end
	end

	always_ff @(posedge clk) begin
		res_status_s1 <= cmd.res_status;
		res_last_s1   <= cmd.res_last;
		res_entry_s1  <= cmd.res_entry;
	end

	// Push and pop answers carry zero data.
	assign strobe = res_valid_s1;
	assign status = res_status_s1;
	assign last   = res_last_s1;
	assign data   = res_entry_s1 ? signed'(rd_data_s1) : '0;

endmodule

// ----- sv/fifo_queue_with_dump.sv -----
`timescale 1ns / 1ps
// Top level of the FIFO queue with dump: joins the controller and the datapath.
// Depends on fqd_pkg, fqd_ctrl and fqd_dp.
//
//   Channel   Handshake         Payload ports
//   -------   ---------------   -------------------------
//   input     start, busy       opcode, value
//   result    strobe            data, status, last
//
// A push or a pop is answered on the result ports in the cycle after it is taken, and a
// new word may be taken every cycle while busy is low.
// A dump of N entries holds busy high through its N ring memory reads, one per cycle,
// and each entry comes out in the cycle after its read, oldest first.
// An empty dump and the unused opcode give no result.
// Reset clears head, tail and count; the ring contents are not cleared.
// Results are shown for one cycle each and the receiver cannot stall them.
module fifo_queue_with_dump #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       opcode,
	input  logic signed [fqd_pkg::DATA_W-1:0] value,
	output logic                             strobe,
	output logic signed [fqd_pkg::DATA_W-1:0] data,
	output logic [1:0]                       status,
	output logic                             last
);

	fqd_pkg::dp_cmd_t  cmd;
	fqd_pkg::dp_stat_t stat;

	// Opcode decode and dump sequencing.
	fqd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Ring storage, pointers and result register.
	fqd_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.value  (value),
		.cmd    (cmd),
		.stat   (stat),
		.strobe (strobe),
		.data   (data),
		.status (status),
		.last   (last)
	);

`ifndef SYNTHESIS
	// While a dump runs, every result word is a dump entry.
	a_busy_entry: assert property (@(posedge clk) disable iff (!arst_n)
		busy && strobe |-> status == fqd_pkg::ST_ENTRY)
		else $error("non-entry result during dump");

	// Push and pop answers are single words.
	a_answer_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status != fqd_pkg::ST_ENTRY |-> last)
		else $error("answer word without last");

	// The end of a dump is followed at once by its final entry.
	a_dump_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && last && status == fqd_pkg::ST_ENTRY)
		else $error("dump ended without its final entry");
`endif

endmodule

// ----- tb/fqd_checker.sv -----
`timescale 1ns / 1ps
// Checker for the FIFO queue with dump: watches the command and result channels,
// predicts the answers of each accepted command word and compares them in order.
// Depends on fqd_pkg.
module fqd_checker #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic [1:0]                        opcode,
	input  logic signed [fqd_pkg::DATA_W-1:0] value,
	input  logic                              strobe,
	input  logic signed [fqd_pkg::DATA_W-1:0] data,
	input  logic [1:0]                        status,
	input  logic                              last,
	output int                                errors,
	output int                                pending,
	output int                                level,
	output int                                n_words,
	output int                                n_dumps,
	output int                                n_results,
	output int                                n_full,
	output int                                n_empty
);

	// One expected result word.
	typedef struct packed {
		logic signed [fqd_pkg::DATA_W-1:0] data;
		logic [1:0]                        status;
		logic                              last;
	} answer_t;

	answer_t                           answers_due[$];
	logic signed [fqd_pkg::DATA_W-1:0] ring_copy [DEPTH];
	int unsigned                       head_ix;
	int unsigned                       tail_ix;
	int unsigned                       fill;

	initial begin
		errors    = 0;
		pending   = 0;
		level     = 0;
		n_words   = 0;
		n_dumps   = 0;
		n_results = 0;
		n_full    = 0;
		n_empty   = 0;
		head_ix   = 0;
		tail_ix   = 0;
		fill      = 0;
	end

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(input string what);
		errors++;
		$display("%0t ns: MISMATCH: %s", $time, what);
	endtask

	function automatic int unsigned ring_next(input int unsigned ix);
		return (ix + 1 == DEPTH) ? 0 : ix + 1;
	endfunction

	task automatic expect_answer(input logic signed [fqd_pkg::DATA_W-1:0] d,
	                             input logic [1:0] st, input logic lst);
		answer_t a;
		a.data   = d;
		a.status = st;
		a.last   = lst;
		answers_due.push_back(a);
	endtask

	// Queue model: works out the answers of one accepted command word.
	task automatic apply_command(input logic [1:0] op,
	                             input logic signed [fqd_pkg::DATA_W-1:0] val);
		int unsigned ix;
		case (op)
			fqd_pkg::OP_PUSH: begin
				n_words++;
				if (fill >= DEPTH) begin
					n_full++;
					expect_answer('0, fqd_pkg::ST_FULL, 1'b1);
				end else begin
					ring_copy[tail_ix] = val;
					tail_ix = ring_next(tail_ix);
					fill++;
					expect_answer('0, fqd_pkg::ST_OK, 1'b1);
				end
			end
			fqd_pkg::OP_POP: begin
				n_words++;
				if (fill == 0) begin
					n_empty++;
					expect_answer('0, fqd_pkg::ST_EMPTY, 1'b1);
				end else begin
					head_ix = ring_next(head_ix);
					fill--;
					expect_answer('0, fqd_pkg::ST_OK, 1'b1);
				end
			end
			fqd_pkg::OP_DUMP: begin
				n_words++;
				n_dumps++;
				ix = head_ix;
				for (int k = 0; k < fill; k++) begin
					expect_answer(ring_copy[ix], fqd_pkg::ST_ENTRY, (k + 1 == fill));
					ix = ring_next(ix);
				end
			end
			default: begin
				// The unused opcode is ignored by the block.
			end
		endcase
	endtask

	// Result words are checked before the command accepted at the same edge is
	// modelled, since no command answers within its own cycle.
	always @(posedge clk) begin : watch
		answer_t due;
		if (!arst_n) begin
			head_ix = 0;
			tail_ix = 0;
			fill    = 0;
			answers_due.delete();
		end else begin
			if (strobe === 1'b1) begin
				n_results++;
				if (answers_due.size() == 0) begin
					report_mismatch($sformatf("unexpected result word data=%0d status=%0d last=%0b",
						data, status, last));
				end else begin
					due = answers_due.pop_front();
					if (data !== due.data)
						report_mismatch($sformatf("data %0d, expected %0d", data, due.data));
					if (status !== due.status)
						report_mismatch($sformatf("status %0d, expected %0d", status, due.status));
					if (last !== due.last)
						report_mismatch($sformatf("last %0b, expected %0b", last, due.last));
				end
			end else if (strobe !== 1'b0) begin
				report_mismatch("strobe is unknown");
			end
			if (start === 1'b1 && busy === 1'b0) begin
				apply_command(opcode, value);
			end
		end
		pending = answers_due.size();
		level   = fill;
	end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Testbench top for the FIFO queue with dump: clock, reset and command stimulus,
// with the checker beside the block giving the verdict's failure count.
// Depends on fqd_pkg, fifo_queue_with_dump and fqd_checker.
module testbench;

	localparam int unsigned DEPTH = 16;

	// Opcode that the block ignores.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic signed [fqd_pkg::DATA_W-1:0] V_MIN = 32'h8000_0000;
	localparam logic signed [fqd_pkg::DATA_W-1:0] V_MAX = 32'h7FFF_FFFF;
	localparam logic signed [fqd_pkg::DATA_W-1:0] V_ONES = 32'hFFFF_FFFF;

	logic                              clk;
	logic                              arst_n;
	logic                              start;
	logic                              busy;
	logic [1:0]                        opcode;
	logic signed [fqd_pkg::DATA_W-1:0] value;
	logic                              strobe;
	logic signed [fqd_pkg::DATA_W-1:0] data;
	logic [1:0]                        status;
	logic                              last;

	int errors;
	int pending;
	int level;
	int n_words;
	int n_dumps;
	int n_results;
	int n_full;
	int n_empty;
	int idle_pct;

	fifo_queue_with_dump #(
		.DEPTH(DEPTH)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.opcode(opcode),
		.value (value),
		.strobe(strobe),
		.data  (data),
		.status(status),
		.last  (last)
	);

	fqd_checker #(
		.DEPTH(DEPTH)
	) u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.opcode   (opcode),
		.value    (value),
		.strobe   (strobe),
		.data     (data),
		.status   (status),
		.last     (last),
		.errors   (errors),
		.pending  (pending),
		.level    (level),
		.n_words  (n_words),
		.n_dumps  (n_dumps),
		.n_results(n_results),
		.n_full   (n_full),
		.n_empty  (n_empty)
	);

	// Clock with a period of 2 ns.
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Run limit, far above the slowest correct run.
	initial begin
		#200_000;
		$display("Run limit reached with %0d result words outstanding.", pending);
		$display("** fifo_queue_with_dump: FAILED **");
		$finish;
	end

	// Random values in half the picks; the other half are the extremes of the field, zero and all ones.
	function automatic logic signed [fqd_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(7))
			0: return V_MIN;
			1: return V_MAX;
			2: return '0;
			3: return V_ONES;
			default: return $urandom;
		endcase
	endfunction

	// Opcode mix leaning towards filling or towards draining the queue.
	function automatic logic [1:0] pick_opcode(input bit filling);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 5)
			return OP_UNUSED;
		else if (r < 15)
			return fqd_pkg::OP_DUMP;
		else if (r < 85)
			return filling ? fqd_pkg::OP_PUSH : fqd_pkg::OP_POP;
		else
			return filling ? fqd_pkg::OP_POP : fqd_pkg::OP_PUSH;
	endfunction

	// Offers one command word, after random idle cycles, and waits until it is taken.
	task automatic send_word(input logic [1:0] op,
	                         input logic signed [fqd_pkg::DATA_W-1:0] val);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start  <= 1'b0;
			opcode <= 2'($urandom_range(3));
			value  <= $urandom;
		end
		@(negedge clk);
		start  <= 1'b1;
		opcode <= op;
		value  <= val;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	initial begin : stimulus
		int  phase_idle [4];
		int  sent;
		bit  filling;
		logic [1:0] op;

		phase_idle = '{0, 69, 15, 0};
		idle_pct = 0;
		arst_n   = 1'b0;
		start    = 1'b0;
		opcode   = fqd_pkg::OP_PUSH;
		value    = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part: empty cases, the unused opcode, the value extremes,
		// a push into a full queue and a dump of a full queue.
		send_word(fqd_pkg::OP_POP, 32'sd5);
		send_word(fqd_pkg::OP_DUMP, V_MAX);
		send_word(OP_UNUSED, V_MAX);
		send_word(fqd_pkg::OP_PUSH, V_MIN);
		send_word(fqd_pkg::OP_PUSH, V_MAX);
		send_word(fqd_pkg::OP_PUSH, '0);
		send_word(fqd_pkg::OP_PUSH, V_ONES);
		send_word(fqd_pkg::OP_DUMP, '0);
		send_word(fqd_pkg::OP_POP, V_MIN);
		repeat (DEPTH - 3) send_word(fqd_pkg::OP_PUSH, pick_value());
		send_word(fqd_pkg::OP_PUSH, V_MIN);
		send_word(fqd_pkg::OP_DUMP, V_ONES);
		send_word(OP_UNUSED, V_MIN);

		// Random part in phases of sender idling; the opcode mix swings between
		// filling and draining so that full and empty are reached repeatedly.
		filling = 1'b0;
		foreach (phase_idle[p]) begin
			idle_pct = phase_idle[p];
			sent = 0;
			while (sent < 38) begin
				if (filling && (level == DEPTH || $urandom_range(39) == 0) &&
				    $urandom_range(2) == 0)
					filling = 1'b0;
				else if (!filling && (level == 0 || $urandom_range(39) == 0) &&
				         $urandom_range(2) == 0)
					filling = 1'b1;
				op = pick_opcode(filling);
				send_word(op, pick_value());
				if (op != OP_UNUSED)
					sent++;
			end
		end
		@(negedge clk);
		start <= 1'b0;

		// Drain the outstanding results, then watch a little longer for strays.
		while (pending != 0) @(posedge clk);
		repeat (2 * DEPTH) @(posedge clk);

		$display("Sent %0d commands including %0d dumps; checked %0d result words.",
			n_words, n_dumps, n_results);
		$display("Pushes into a full queue: %0d; pops from an empty queue: %0d.",
			n_full, n_empty);
		if (errors == 0 && pending == 0) begin
			$display("** fifo_queue_with_dump: PASSED **");
		end else begin
			$display("** fifo_queue_with_dump: FAILED **");
		end
		$finish;
	end

endmodule

// ----- fifo_queue_with_dump.f -----
sv/fqd_pkg.sv
sv/fqd_ctrl.sv
sv/fqd_dp.sv
sv/fifo_queue_with_dump.sv
tb/fqd_checker.sv
tb/testbench.sv
